[sv/dasp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_pkg
// Shared widths, register map and word types of the distance-attenuated
// stereo pan block.
// ----------------------------------------------------------------------------
package dasp_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int RIGHT_WIDTH    = 16;
  localparam int RIGHT_FRAC     = 14;
  localparam int RADIUS_WIDTH   = 23;

  localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
  localparam int SQ_WIDTH       = 2 * RADIUS_WIDTH;
  localparam int SUM_WIDTH      = SQ_WIDTH + 2;
  localparam int DOT_TERM_WIDTH = DIFF_WIDTH + RIGHT_WIDTH;
  localparam int DOT_WIDTH      = DOT_TERM_WIDTH + 2;
  localparam int PDEN_WIDTH     = RADIUS_WIDTH + RIGHT_FRAC;
  localparam int GAIN_WIDTH     = GAIN_FRAC_BITS + 1;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_IDX_RADIUS = 1'b0;

  localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = RADIUS_WIDTH'(7168);
  // 1 m, stands in for a zero distance in the pan divide
  localparam logic [RADIUS_WIDTH-1:0] UNIT_LEN     = RADIUS_WIDTH'(256);

  typedef struct packed {
    logic                          source_valid;
    logic                          listener_valid;
    logic signed [COORD_WIDTH-1:0] source_x;
    logic signed [COORD_WIDTH-1:0] source_y;
    logic signed [COORD_WIDTH-1:0] source_z;
    logic signed [COORD_WIDTH-1:0] listener_x;
    logic signed [COORD_WIDTH-1:0] listener_y;
    logic signed [COORD_WIDTH-1:0] listener_z;
    logic signed [RIGHT_WIDTH-1:0] right_x;
    logic signed [RIGHT_WIDTH-1:0] right_y;
    logic signed [RIGHT_WIDTH-1:0] right_z;
  } in_word_t;

  typedef struct packed {
    logic                  stop_source;
    logic [GAIN_WIDTH-1:0] gain_left;
    logic [GAIN_WIDTH-1:0] gain_right;
  } out_word_t;

  // sideband carried through the square root
  typedef struct packed {
    logic                        stop;
    logic                        zero;
    logic signed [DOT_WIDTH-1:0] dot;
  } sqrt_side_t;

  // sideband carried through the attenuation divide
  typedef struct packed {
    logic                  stop;
    logic                  zero;
    logic                  neg;
    logic [DOT_WIDTH-1:0]  mag;
    logic [PDEN_WIDTH-1:0] den;
  } atten_side_t;

  // sideband carried through the pan divide
  typedef struct packed {
    logic                  stop;
    logic                  zero;
    logic                  neg;
    logic [GAIN_WIDTH-1:0] a;
  } pan_side_t;

endpackage

[sv/distance_attenuated_stereo_pan_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_attenuated_stereo_pan_top
// Left/right gains from source and listener positions and a right vector.
//
// One word enters per clock and one result word leaves per clock while the
// output is not stalled; there are 4 front stages, 23 square-root stages, two
// 17-stage fraction dividers and 3 gain stages. Each stage loads when it is
// empty or its successor moves, so a stalled output holds the words in place
// while empty stages further up keep taking new words. A word with an active
// source but no listener makes no result; its slot travels down the pipe
// empty. The radius register sits at byte address 0; write it only while the
// block is idle.
// ----------------------------------------------------------------------------
module distance_attenuated_stereo_pan_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dasp_pkg::in_word_t                  in_data,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output dasp_pkg::out_word_t                 out_data,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dasp_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [dasp_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [dasp_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                                pready
);
  import dasp_pkg::*;

  // --- register file -------------------------------------------------------
  logic                    reg_idx;
  logic [RADIUS_WIDTH-1:0] radius_r;
  logic [SQ_WIDTH-1:0]     radius_sq_r;

  assign reg_idx = paddr[APB_ADDR_WIDTH-1];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_IDX_RADIUS) ? APB_DATA_WIDTH'(radius_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_IDX_RADIUS)) begin
      radius_r <= pwdata[RADIUS_WIDTH-1:0];
    end
  end

  // R^2 for the range check; registered from the radius, so it follows a write
  // in the next cycle, well before any word reaches the compare
  always_ff @(posedge clk) begin
    radius_sq_r <= SQ_WIDTH'(radius_r) * SQ_WIDTH'(radius_r);
  end

  // --- front: differences, squares, dot product ---------------------------
  logic                f_valid, f_ready;
  logic [SQ_WIDTH-1:0] f_sum;
  sqrt_side_t          f_side;

  dasp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .radius    (radius_r),
    .radius_sq (radius_sq_r),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_sum   (f_sum),
    .out_side  (f_side)
  );

  // --- distance ------------------------------------------------------------
  logic                    s_valid, s_ready;
  logic [RADIUS_WIDTH-1:0] s_dist;
  logic [$bits(sqrt_side_t)-1:0] s_side_v;
  sqrt_side_t              s_side;

  dasp_isqrt #(
    .IN_W (SQ_WIDTH),
    .SB_W ($bits(sqrt_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_rad    (f_sum),
    .in_side   (f_side),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_root  (s_dist),
    .out_side  (s_side_v)
  );

  assign s_side = s_side_v;

  // --- attenuation divide: (R - dist) / R ----------------------------------
  // Also sets up the pan operands: |dot| over (dist, or 1 m at zero) << 14.
  logic [RADIUS_WIDTH-1:0] pan_len;
  atten_side_t             a_in_side;
  logic                    a_valid, a_ready;
  logic [GAIN_WIDTH-1:0]   a_q;
  logic [$bits(atten_side_t)-1:0] a_side_v;
  atten_side_t             a_side;

  assign pan_len        = (s_dist == '0) ? UNIT_LEN : s_dist;
  assign a_in_side.stop = s_side.stop;
  assign a_in_side.zero = s_side.zero;
  assign a_in_side.neg  = s_side.dot[DOT_WIDTH-1];
  assign a_in_side.mag  = s_side.dot[DOT_WIDTH-1] ? DOT_WIDTH'(-s_side.dot)
                                                  : DOT_WIDTH'(s_side.dot);
  assign a_in_side.den  = {pan_len, {RIGHT_FRAC{1'b0}}};

  dasp_frac_div #(
    .NUM_W (RADIUS_WIDTH),
    .DEN_W (RADIUS_WIDTH),
    .QF    (GAIN_FRAC_BITS),
    .SB_W  ($bits(atten_side_t))
  ) u_div_atten (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_num    (radius_r - s_dist),
    .in_den    (radius_r),
    .in_side   (a_in_side),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_q     (a_q),
    .out_side  (a_side_v)
  );

  assign a_side = a_side_v;

  // --- pan divide: |dot| / (len << 14), saturating at unity ---------------
  pan_side_t             p_in_side;
  logic                  p_valid, p_ready;
  logic [GAIN_WIDTH-1:0] p_q;
  logic [$bits(pan_side_t)-1:0] p_side_v;
  pan_side_t             p_side;

  assign p_in_side.stop = a_side.stop;
  assign p_in_side.zero = a_side.zero;
  assign p_in_side.neg  = a_side.neg;
  assign p_in_side.a    = a_q;

  dasp_frac_div #(
    .NUM_W (DOT_WIDTH),
    .DEN_W (PDEN_WIDTH),
    .QF    (GAIN_FRAC_BITS),
    .SB_W  ($bits(pan_side_t))
  ) u_div_pan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_num    (a_side.mag),
    .in_den    (a_side.den),
    .in_side   (p_in_side),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_q     (p_q),
    .out_side  (p_side_v)
  );

  assign p_side = p_side_v;

  // --- gains and output register ------------------------------------------
  dasp_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_q      (p_q),
    .in_side   (p_side),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[sv/dasp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_front
// Differences, range check, squares, dot product and squared distance,
// four register stages.
// ----------------------------------------------------------------------------
module dasp_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dasp_pkg::in_word_t                in_data,
  input  logic [dasp_pkg::RADIUS_WIDTH-1:0] radius,
  input  logic [dasp_pkg::SQ_WIDTH-1:0]     radius_sq,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dasp_pkg::SQ_WIDTH-1:0]     out_sum,
  output dasp_pkg::sqrt_side_t              out_side
);
  import dasp_pkg::*;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: differences
  logic signed [DIFF_WIDTH-1:0]  dx1_r, dy1_r, dz1_r;
  logic signed [RIGHT_WIDTH-1:0] rx1_r, ry1_r, rz1_r;
  logic                          stop1_r;
  logic                          v1_nxt;

  // stage 2: magnitudes, range check
  logic [DIFF_WIDTH-1:0]         ax, ay, az;
  logic                          far2_nxt;
  logic [RADIUS_WIDTH-1:0]       mx2_r, my2_r, mz2_r;
  logic signed [DIFF_WIDTH-1:0]  dx2_r, dy2_r, dz2_r;
  logic signed [RIGHT_WIDTH-1:0] rx2_r, ry2_r, rz2_r;
  logic                          stop2_r, far2_r;

  // stage 3: products
  logic [SQ_WIDTH-1:0]              sx3_r, sy3_r, sz3_r;
  logic signed [DOT_TERM_WIDTH-1:0] tx3_r, ty3_r, tz3_r;
  logic                             stop3_r, far3_r;

  // stage 4: sums
  logic [SUM_WIDTH-1:0]        sum4;
  logic signed [DOT_WIDTH-1:0] dot4;
  logic                        zero4;
  logic [SQ_WIDTH-1:0]         sum4_r;
  sqrt_side_t                  side4_r;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // an active source with no listener gives no word
  assign v1_nxt = in_valid && (!in_data.source_valid || in_data.listener_valid);

  assign ax = dx1_r[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx1_r) : DIFF_WIDTH'(dx1_r);
  assign ay = dy1_r[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy1_r) : DIFF_WIDTH'(dy1_r);
  assign az = dz1_r[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dz1_r) : DIFF_WIDTH'(dz1_r);
  assign far2_nxt = (ax >= DIFF_WIDTH'(radius)) || (ay >= DIFF_WIDTH'(radius)) ||
                    (az >= DIFF_WIDTH'(radius));

  assign sum4  = SUM_WIDTH'(sx3_r) + SUM_WIDTH'(sy3_r) + SUM_WIDTH'(sz3_r);
  assign dot4  = DOT_WIDTH'(tx3_r) + DOT_WIDTH'(ty3_r) + DOT_WIDTH'(tz3_r);
  assign zero4 = stop3_r || far3_r || (sum4 >= SUM_WIDTH'(radius_sq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= v1_nxt;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx1_r   <= DIFF_WIDTH'(in_data.source_x) - DIFF_WIDTH'(in_data.listener_x);
      dy1_r   <= DIFF_WIDTH'(in_data.source_y) - DIFF_WIDTH'(in_data.listener_y);
      dz1_r   <= DIFF_WIDTH'(in_data.source_z) - DIFF_WIDTH'(in_data.listener_z);
      rx1_r   <= in_data.right_x;
      ry1_r   <= in_data.right_y;
      rz1_r   <= in_data.right_z;
      stop1_r <= !in_data.source_valid;
    end
    if (rdy2) begin
      mx2_r   <= ax[RADIUS_WIDTH-1:0];
      my2_r   <= ay[RADIUS_WIDTH-1:0];
      mz2_r   <= az[RADIUS_WIDTH-1:0];
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
      dz2_r   <= dz1_r;
      rx2_r   <= rx1_r;
      ry2_r   <= ry1_r;
      rz2_r   <= rz1_r;
      stop2_r <= stop1_r;
      far2_r  <= far2_nxt;
    end
    if (rdy3) begin
      sx3_r   <= SQ_WIDTH'(mx2_r) * SQ_WIDTH'(mx2_r);
      sy3_r   <= SQ_WIDTH'(my2_r) * SQ_WIDTH'(my2_r);
      sz3_r   <= SQ_WIDTH'(mz2_r) * SQ_WIDTH'(mz2_r);
      tx3_r   <= DOT_TERM_WIDTH'(dx2_r) * DOT_TERM_WIDTH'(rx2_r);
      ty3_r   <= DOT_TERM_WIDTH'(dy2_r) * DOT_TERM_WIDTH'(ry2_r);
      tz3_r   <= DOT_TERM_WIDTH'(dz2_r) * DOT_TERM_WIDTH'(rz2_r);
      stop3_r <= stop2_r;
      far3_r  <= far2_r;
    end
    if (rdy4) begin
      sum4_r       <= zero4 ? '0 : sum4[SQ_WIDTH-1:0];
      side4_r.stop <= stop3_r;
      side4_r.zero <= zero4;
      side4_r.dot  <= dot4;
    end
  end

  assign out_valid = v4_r;
  assign out_sum   = sum4_r;
  assign out_side  = side4_r;

endmodule

[sv/dasp_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_isqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module dasp_isqrt #(
  parameter int IN_W = 46,
  parameter int SB_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IN_W-1:0]   in_rad,
  input  logic [SB_W-1:0]   in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_side
);
  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int NSTG   = ROOT_W;

  logic              v_r    [NSTG];
  logic [IN_W-1:0]   x_r    [NSTG];
  logic [REM_W-1:0]  rem_r  [NSTG];
  logic [ROOT_W-1:0] root_r [NSTG];
  logic [SB_W-1:0]   sb_r   [NSTG];
  logic [NSTG:0]     rdy;

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic              v_in;
    logic [IN_W-1:0]   x_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [SB_W-1:0]   sb_in;
    logic [REM_W-1:0]  rem_sh, trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign sb_in   = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], x_in[IN_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign fit    = rem_sh >= trial;
    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        x_r[k]    <= {x_in[IN_W-3:0], 2'b00};
        rem_r[k]  <= fit ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_in[ROOT_W-2:0], fit};
        sb_r[k]   <= sb_in;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_root  = root_r[NSTG-1];
  assign out_side  = sb_r[NSTG-1];

endmodule

[sv/dasp_frac_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_frac_div
// Pipelined fraction divide: 2^QF when num >= den, else floor(num*2^QF/den).
// One setup stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module dasp_frac_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 23,
  parameter int QF    = 16,
  parameter int SB_W  = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [QF:0]      out_q,
  output logic [SB_W-1:0]  out_side
);
  localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;
  localparam int NSTG  = QF + 1;

  logic             v_r   [NSTG];
  logic             sat_r [NSTG];
  logic [DEN_W-1:0] rem_r [NSTG];
  logic [DEN_W-1:0] den_r [NSTG];
  logic [QF-1:0]    q_r   [NSTG];
  logic [SB_W-1:0]  sb_r  [NSTG];
  logic [NSTG:0]    rdy;

  assign rdy[NSTG] = out_ready;
  assign in_ready  = rdy[0];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic             v_nxt;
    logic             sat_nxt;
    logic [DEN_W-1:0] rem_nxt;
    logic [DEN_W-1:0] den_nxt;
    logic [QF-1:0]    q_nxt;
    logic [SB_W-1:0]  sb_nxt;

    if (k == 0) begin : g_setup
      assign v_nxt   = in_valid;
      assign sat_nxt = CMP_W'(in_num) >= CMP_W'(in_den);
      assign rem_nxt = sat_nxt ? '0 : DEN_W'(CMP_W'(in_num));
      assign den_nxt = in_den;
      assign q_nxt   = '0;
      assign sb_nxt  = in_side;
    end else begin : g_step
      logic [DEN_W:0] t;
      logic           ge;
      assign t       = {rem_r[k-1], 1'b0};
      assign ge      = t >= {1'b0, den_r[k-1]};
      assign v_nxt   = v_r[k-1];
      assign sat_nxt = sat_r[k-1];
      assign rem_nxt = ge ? DEN_W'(t - {1'b0, den_r[k-1]}) : DEN_W'(t);
      assign den_nxt = den_r[k-1];
      assign q_nxt   = {q_r[k-1][QF-2:0], ge};
      assign sb_nxt  = sb_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_nxt;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        sat_r[k] <= sat_nxt;
        rem_r[k] <= rem_nxt;
        den_r[k] <= den_nxt;
        q_r[k]   <= q_nxt;
        sb_r[k]  <= sb_nxt;
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_q     = sat_r[NSTG-1] ? {1'b1, {QF{1'b0}}} : {1'b0, q_r[NSTG-1]};
  assign out_side  = sb_r[NSTG-1];

endmodule

[sv/dasp_gain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_gain
// Attenuation square, pan weights and the two channel gains, three stages.
// ----------------------------------------------------------------------------
module dasp_gain (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dasp_pkg::GAIN_WIDTH-1:0] in_q,
  input  dasp_pkg::pan_side_t             in_side,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dasp_pkg::out_word_t             out_data
);
  import dasp_pkg::*;

  localparam int ASQ_W = 2 * GAIN_WIDTH;
  localparam int W_W   = GAIN_WIDTH + 1;
  localparam int P_W   = GAIN_WIDTH + W_W;
  localparam logic [ASQ_W-1:0] ASQ_HALF = ASQ_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [W_W-1:0]   ONE_W    = W_W'(1) << GAIN_FRAC_BITS;
  localparam logic [P_W-1:0]   P_ROUND  = P_W'(1) << GAIN_FRAC_BITS;

  logic rdy1, rdy2, rdy3;
  logic v1_r, v2_r, v3_r;

  logic [ASQ_W-1:0]      asq;
  logic [GAIN_WIDTH-1:0] att1_r;
  logic [W_W-1:0]        lw1_r, rw1_r;
  logic                  stop1_r, zero1_r;

  logic [P_W-1:0]        pl2_r, pr2_r;
  logic                  stop2_r, zero2_r;

  logic [P_W-1:0]        gl3, gr3;
  out_word_t             out3_r;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign asq = ASQ_W'(in_side.a) * ASQ_W'(in_side.a);
  assign gl3 = (pl2_r + P_ROUND) >> (GAIN_FRAC_BITS + 1);
  assign gr3 = (pr2_r + P_ROUND) >> (GAIN_FRAC_BITS + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      att1_r  <= GAIN_WIDTH'((asq + ASQ_HALF) >> GAIN_FRAC_BITS);
      // pan = +/- q; left weight 1 - pan, right weight 1 + pan
      lw1_r   <= in_side.neg ? ONE_W + W_W'(in_q) : ONE_W - W_W'(in_q);
      rw1_r   <= in_side.neg ? ONE_W - W_W'(in_q) : ONE_W + W_W'(in_q);
      stop1_r <= in_side.stop;
      zero1_r <= in_side.zero;
    end
    if (rdy2) begin
      pl2_r   <= P_W'(att1_r) * P_W'(lw1_r);
      pr2_r   <= P_W'(att1_r) * P_W'(rw1_r);
      stop2_r <= stop1_r;
      zero2_r <= zero1_r;
    end
    if (rdy3) begin
      out3_r.stop_source <= stop2_r;
      out3_r.gain_left   <= zero2_r ? '0 : gl3[GAIN_WIDTH-1:0];
      out3_r.gain_right  <= zero2_r ? '0 : gr3[GAIN_WIDTH-1:0];
    end
  end

  assign out_valid = v3_r;
  assign out_data  = out3_r;

endmodule

[sv/dasp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_props
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dasp_props (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dasp_pkg::out_word_t out_data
);
  import dasp_pkg::*;

  localparam logic [GAIN_WIDTH:0] GAIN_SUM_MAX = (GAIN_WIDTH + 1)'((1 << GAIN_FRAC_BITS) + 1);

  // a stopped source never carries gain
  a_stop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stop_source |->
      (out_data.gain_left == '0) && (out_data.gain_right == '0))
    else $error("stopped source with nonzero gain");

  // weights add to two and the gains halve them; their sum cannot exceed unity
  a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ((GAIN_WIDTH + 1)'(out_data.gain_left) + (GAIN_WIDTH + 1)'(out_data.gain_right))
        <= GAIN_SUM_MAX)
    else $error("gain sum above unity");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind distance_attenuated_stereo_pan_top dasp_props u_dasp_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[test/dasp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dasp_checker
// Watches the word channels of the stereo pan block, computes the expected
// gains for each accepted input word and compares them with the result words.
// ----------------------------------------------------------------------------
module dasp_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  dasp_pkg::in_word_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  dasp_pkg::out_word_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [dasp_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [dasp_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output int                                  fail_count,
  output int                                  pending
);
  import dasp_pkg::*;

  localparam longint ONE = 64'sd1 <<< GAIN_FRAC_BITS;

  logic [RADIUS_WIDTH-1:0] radius;
  out_word_t gains_q[$];

  function automatic longint root_floor(longint x);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // returns 0 when the word makes no result
  function automatic bit pan_gains(in_word_t w, longint rad, output out_word_t o);
    longint d[3];
    longint rv[3];
    longint sum, root, a, atten, dot, len, den, m, q, pan;
    bit far;
    o = '0;
    if (!w.source_valid) begin
      o.stop_source = 1'b1;
      return 1;
    end
    if (!w.listener_valid) return 0;
    d[0] = longint'(w.source_x) - longint'(w.listener_x);
    d[1] = longint'(w.source_y) - longint'(w.listener_y);
    d[2] = longint'(w.source_z) - longint'(w.listener_z);
    rv[0] = longint'(w.right_x);
    rv[1] = longint'(w.right_y);
    rv[2] = longint'(w.right_z);
    far = 0;
    sum = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      if ((d[i] < 0 ? -d[i] : d[i]) >= rad) far = 1;
      sum += d[i] * d[i];
      dot += d[i] * rv[i];
    end
    if (far || sum >= rad * rad) return 1;
    root = root_floor(sum);
    a = ((rad - root) <<< GAIN_FRAC_BITS) / rad;
    atten = (a * a + (ONE >>> 1)) >>> GAIN_FRAC_BITS;
    len = (root == 0) ? 256 : root;
    den = len <<< RIGHT_FRAC;
    m = dot < 0 ? -dot : dot;
    q = (m >= den) ? ONE : (m <<< GAIN_FRAC_BITS) / den;
    pan = dot < 0 ? -q : q;
    o.gain_left  = GAIN_WIDTH'((atten * (ONE - pan) + ONE) >>> (GAIN_FRAC_BITS + 1));
    o.gain_right = GAIN_WIDTH'((atten * (ONE + pan) + ONE) >>> (GAIN_FRAC_BITS + 1));
    return 1;
  endfunction

  assign pending = gains_q.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      radius <= RADIUS_RESET;
      fail_count <= 0;
      gains_q.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[APB_ADDR_WIDTH-1:2] == REG_IDX_RADIUS)
        radius <= pwdata[RADIUS_WIDTH-1:0];
      if (in_valid && in_ready && pan_gains(in_data, longint'(radius), exp_w))
        gains_q.push_back(exp_w);
      if (out_valid && out_ready) begin
        if (gains_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = gains_q.pop_front();
          if (exp_w !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: exp stop=%0d l=%0d r=%0d got stop=%0d l=%0d r=%0d",
                       exp_w.stop_source, exp_w.gain_left, exp_w.gain_right,
                       out_data.stop_source, out_data.gain_left, out_data.gain_right);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[test/distance_attenuated_stereo_pan_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_attenuated_stereo_pan_top_tb
// Drives position words and radius writes into the stereo pan block under
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module distance_attenuated_stereo_pan_top_tb;
  import dasp_pkg::*;

  localparam int LATENCY = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_word_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;
  int fail_count, pending;

  // idle rates in percent
  int send_idle = 0, recv_idle = 0;
  int quiet = 0;
  logic [RADIUS_WIDTH-1:0] cur_radius = RADIUS_RESET;

  always #5 clk = ~clk;

  distance_attenuated_stereo_pan_top u_top (.*);

  dasp_checker u_chk (.*);

  // receiver stalls at random
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // leaves valid high after the accept; the next send or drain drops it
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // wait until drained, then past the pipeline for words with no result
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_WIDTH-1:0] rad);
    drain();
    psel <= 1; pwrite <= 1; paddr <= {REG_IDX_RADIUS, 2'b00}; pwdata <= 32'(rad);
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cur_radius = rad;
  endtask

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    return COORD_WIDTH'($urandom);
  endfunction

  // mostly positions inside the radius so gains are nonzero
  function automatic in_word_t rand_word();
    in_word_t w;
    int span;
    w = '0;
    w.source_valid = ($urandom_range(19) != 0);
    w.listener_valid = ($urandom_range(9) != 0);
    w.listener_x = rand_coord();
    w.listener_y = rand_coord();
    w.listener_z = rand_coord();
    if ($urandom_range(9) < 8) begin
      span = (cur_radius < 3) ? 1 : cur_radius / 2;
      w.source_x = w.listener_x + COORD_WIDTH'($urandom_range(2 * span) - span);
      w.source_y = w.listener_y + COORD_WIDTH'($urandom_range(2 * span) - span);
      w.source_z = w.listener_z + COORD_WIDTH'($urandom_range(2 * span) - span);
    end else begin
      w.source_x = rand_coord();
      w.source_y = rand_coord();
      w.source_z = rand_coord();
    end
    if ($urandom_range(9) == 0) begin
      w.right_x = RIGHT_WIDTH'($urandom);
      w.right_y = RIGHT_WIDTH'($urandom);
      w.right_z = RIGHT_WIDTH'($urandom);
    end else begin
      w.right_x = RIGHT_WIDTH'($urandom_range(32768) - 16384);
      w.right_y = RIGHT_WIDTH'($urandom_range(32768) - 16384);
      w.right_z = RIGHT_WIDTH'($urandom_range(32768) - 16384);
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    logic [RADIUS_WIDTH-1:0] radii[5];
    radii = '{23'd7168, 23'd1, 23'h7fffff, 23'd300, 23'h400000};
    repeat (11) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: inactive source, no listener, coincident, far, axis pans
    w = '0;
    send_word(w);                       // source inactive
    w.source_valid = 1;
    send_word(w);                       // no listener: no result
    w.listener_valid = 1;
    w.right_x = 16'sd16384;
    send_word(w);                       // zero distance
    w.source_x = 24'd1000;
    send_word(w);                       // full right
    w.source_x = -24'sd1000;
    send_word(w);                       // full left
    w.source_x = 24'h7fffff; w.listener_x = 24'h800000;
    send_word(w);                       // extreme difference, beyond radius
    w.source_x = 24'd7168; w.listener_x = '0;
    send_word(w);                       // exactly at the radius
    w.source_x = 24'd5000; w.source_y = 24'd5000; w.source_z = 24'd5000;
    send_word(w);                       // component inside, sum beyond
    w = '0; w.source_valid = 1; w.listener_valid = 1;
    w.source_y = 24'd100; w.right_x = 16'h8000; w.right_y = 16'h7fff;
    w.right_z = 16'hffff;
    send_word(w);                       // right vector out of range
    w.source_y = '0; w.source_z = -24'sd77; w.right_z = 16'h0001;
    send_word(w);
    w.source_x = 24'h7fffff; w.source_y = 24'h7fffff; w.source_z = 24'h7fffff;
    w.listener_x = 24'h7fffff; w.listener_y = 24'h7fffff; w.listener_z = 24'h7fffff;
    send_word(w);                       // coincident at the corner
    w.listener_valid = 0; w.source_valid = 0;
    send_word(w);

    // random phases, one radius setting each, idling patterns rotated
    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      send_idle = (ph < 2) ? 33 : (ph < 4) ? 48 : 0;
      recv_idle = (ph < 2) ? 48 : (ph < 4) ? 33 : 0;
      for (int n = 0; n < 170; n++) send_word(rand_word());
    end

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
